FILE: rtl/mtf_pkg.sv
// mtf_pkg: sizes and state codes shared by the move-to-front rank table
// no dependencies; imported by the core, the checker and the bench
package mtf_pkg;

    localparam int NUM_COLORS = 64;
    localparam int MAX_DECK   = 4096;

    localparam int COLOR_W = 6;
    localparam int POS_W   = 13;
    localparam int ADDR_W  = (NUM_COLORS > 1) ? $clog2(NUM_COLORS) : 1;
    localparam int CNT_W   = $clog2(MAX_DECK + 1);

    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 16;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_POS   = 4'b0010,
        ST_SWEEP = 4'b0100,
        ST_EMIT  = 4'b1000
    } mtf_state_t;

endpackage

FILE: rtl/mtf_ram.sv
// mtf_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module mtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/move_to_front_rank_table_core.sv
// channel | ports                              | contents
// input   | s_tvalid s_tready s_tdata s_tuser  | tdata: color; tuser: opcode
// result  | m_tvalid m_tready m_tdata m_tuser  | tdata: position; tuser: not_found
//
// a load is written in the cycle it is accepted; a query passes ST_POS and then
// the ST_SWEEP pass that reads and rewrites every rank table entry through the ram
// before ST_EMIT; a query for an absent color goes from ST_POS straight to ST_EMIT
// reset clears the card count and the per-entry valid flags at once, no clearing pass
// a stalled result waits in the output register; the next item is taken meanwhile
// move_to_front_rank_table_core: top level, depends on mtf_pkg and mtf_ram
module move_to_front_rank_table_core
    import mtf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [5:0] color
    input  logic [0:0]          s_tuser,   // [0] opcode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [12:0] position
    output logic [0:0]          m_tuser    // [0] not_found
);

    mtf_state_t state_reg, state_next;

    logic [ADDR_W-1:0]     color_reg, color_next;
    logic                  known_reg, known_next;
    logic [CNT_W-1:0]      pos_reg, pos_next;
    logic                  nf_reg, nf_next;
    logic [ADDR_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]      cards_reg, cards_next;
    logic [NUM_COLORS-1:0] valid_reg, valid_next;
    logic                  m_valid_reg, m_valid_next;
    logic [POS_W-1:0]      m_pos_reg, m_pos_next;
    logic                  m_nf_reg, m_nf_next;

    logic                  we;
    logic [ADDR_W-1:0]     waddr, raddr;
    logic [CNT_W-1:0]      wdata, rdata;

    logic [COLOR_W-1:0]    in_color;
    logic [ADDR_W-1:0]     in_addr;
    logic                  in_known;
    logic                  accept;

    assign in_color = s_tdata[COLOR_W-1:0];
    assign in_addr  = ADDR_W'(in_color);
    assign in_known = 32'(in_color) < 32'(NUM_COLORS);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    mtf_ram #(
        .WIDTH(CNT_W),
        .DEPTH(NUM_COLORS)
    ) u_rank_ram (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_comb begin
        state_next   = state_reg;
        color_next   = color_reg;
        known_next   = known_reg;
        pos_next     = pos_reg;
        nf_next      = nf_reg;
        idx_next     = idx_reg;
        cards_next   = cards_reg;
        valid_next   = valid_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_pos_next   = m_pos_reg;
        m_nf_next    = m_nf_reg;
        we           = 1'b0;
        waddr        = idx_reg;
        wdata        = rdata;
        raddr        = idx_reg + ADDR_W'(1);

        unique case (state_reg)
            ST_IDLE: begin
                raddr = in_addr;
                if (accept) begin
                    if (s_tuser[0] == OP_LOAD) begin
                        if (32'(cards_reg) < 32'(MAX_DECK)) begin
                            cards_next = cards_reg + CNT_W'(1);
                            if (in_known && !valid_reg[in_addr]) begin
                                we                  = 1'b1;
                                waddr               = in_addr;
                                wdata               = cards_next;
                                valid_next[in_addr] = 1'b1;
                            end
                        end
                    end else begin
                        color_next = in_addr;
                        known_next = in_known;
                        state_next = ST_POS;
                    end
                end
            end
            ST_POS: begin
                raddr    = '0;
                idx_next = '0;
                if (known_reg && valid_reg[color_reg]) begin
                    pos_next   = rdata;
                    nf_next    = 1'b0;
                    state_next = ST_SWEEP;
                end else begin
                    pos_next   = '0;
                    nf_next    = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_SWEEP: begin
                // entry idx_reg is on the read port, entry idx_reg+1 is being fetched
                waddr = idx_reg;
                if (idx_reg == color_reg) begin
                    we    = 1'b1;
                    wdata = CNT_W'(1);
                end else if (valid_reg[idx_reg] && rdata < pos_reg) begin
                    we    = 1'b1;
                    wdata = rdata + CNT_W'(1);
                end
                idx_next = idx_reg + ADDR_W'(1);
                if (32'(idx_reg) == NUM_COLORS - 1) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_pos_next   = POS_W'(pos_reg);
                    m_nf_next    = nf_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cards_reg   <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cards_reg   <= cards_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        color_reg <= color_next;
        known_reg <= known_next;
        pos_reg   <= pos_next;
        nf_reg    <= nf_next;
        idx_reg   <= idx_next;
        m_pos_reg <= m_pos_next;
        m_nf_reg  <= m_nf_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'(m_pos_reg);
    assign m_tuser  = m_nf_reg;

endmodule

FILE: rtl/mtf_checker.sv
// mtf_checker: port-level checks on the rank table core, bound to the top level
// depends on mtf_pkg and move_to_front_rank_table_core
module mtf_checker
    import mtf_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic [0:0]          s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [0:0]          m_tuser
);

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_absent_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("not-found result with nonzero position");

    a_found_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[POS_W-1:0] != '0)
        else $error("found result with zero position");

    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == OP_QUERY) |=> !s_tready)
        else $error("input taken while a query is in progress");

endmodule

bind move_to_front_rank_table_core mtf_checker u_mtf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);

FILE: test/tb_move_to_front_rank_table_core.sv
// tb_move_to_front_rank_table_core: self-checking bench for the move-to-front rank table
// drives load and query transfers with random bursts and back-pressure, predicts every result
// depends on mtf_pkg and move_to_front_rank_table_core
module tb_move_to_front_rank_table_core;
    import mtf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             not_found;
    } rank_result_t;

    localparam int WATCHDOG_CYCLES = 1000000;
    localparam int TAIL_CYCLES     = 100;
    localparam int HOLD_CYCLES     = 700;
    localparam int MAX_REPORTS     = 64;

    localparam int RX_FREE  = 0;
    localparam int RX_CHOP  = 1;
    localparam int RX_STALL = 2;

    // never loaded before the full-deck test
    localparam logic [COLOR_W-1:0] SPARE_A = 6'd37;
    localparam logic [COLOR_W-1:0] SPARE_B = 6'd26;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [0:0]          s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [0:0]          m_tuser;

    logic [POS_W-1:0] deck_rank [NUM_COLORS];
    int               cards_seen = 0;
    rank_result_t     ranks_due [$];
    rank_result_t     want_rank;

    int   mismatch_cnt  = 0;
    int   cycle_cnt     = 0;
    int   burst_left    = 0;
    logic offering      = 1'b0;
    int   hold_requests = 0;
    int   hold_served   = 0;
    int   hold_left     = 0;
    int   rx_mode       = RX_FREE;
    int   rx_left       = 0;

    move_to_front_rank_table_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // deck model: update on every accepted transfer, queue the answer of a query
    function automatic void apply_card(input logic op, input logic [COLOR_W-1:0] color);
        rank_result_t     res;
        logic [POS_W-1:0] pos;
        if (op == OP_LOAD) begin
            if (cards_seen < MAX_DECK) begin
                cards_seen++;
                if (color < NUM_COLORS && deck_rank[color] == '0)
                    deck_rank[color] = cards_seen[POS_W-1:0];
            end
        end else begin
            pos = (color < NUM_COLORS) ? deck_rank[color] : '0;
            if (pos == '0) begin
                res.position  = '0;
                res.not_found = 1'b1;
            end else begin
                for (int k = 0; k < NUM_COLORS; k++) begin
                    if (deck_rank[k] != '0 && deck_rank[k] < pos)
                        deck_rank[k] = deck_rank[k] + 1'b1;
                end
                deck_rank[color] = 13'd1;
                res.position  = pos;
                res.not_found = 1'b0;
            end
            ranks_due = {ranks_due, res};
        end
    endfunction

    function automatic logic [COLOR_W-1:0] pick_present();
        logic [COLOR_W-1:0] c;
        c = COLOR_W'($urandom_range(0, NUM_COLORS - 1));
        for (int t = 0; t < 16 && deck_rank[c] == '0; t++)
            c = COLOR_W'($urandom_range(0, NUM_COLORS - 1));
        return c;
    endfunction

    function automatic logic [COLOR_W-1:0] pick_load_color();
        logic [COLOR_W-1:0] c;
        c = COLOR_W'($urandom_range(0, NUM_COLORS - 1));
        if (c == SPARE_A || c == SPARE_B)
            c = c ^ 6'd1;
        return c;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        if (mismatch_cnt < MAX_REPORTS)
            $display("mismatch at cycle %0d: %s expected %0d got %0d", cycle_cnt, what, want, got);
        mismatch_cnt++;
    endtask

    task automatic stop_offer();
        if (offering) begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic send_item(input logic op, input logic [COLOR_W-1:0] color);
        s_tuser <= op;
        s_tdata <= {{(S_DATA_W - COLOR_W){1'b0}}, color};
        if (!offering) begin
            s_tvalid <= 1'b1;
            offering = 1'b1;
        end
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        apply_card(op, color);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            if ($urandom_range(0, 3) != 0) begin
                stop_offer();
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_for_ranks();
        if (offering) begin
            stop_offer();
            @(posedge aclk);
        end
        while (ranks_due.size() != 0)
            @(posedge aclk);
    endtask

    task automatic test_directed_moves();
        send_item(OP_QUERY, 6'd0);
        send_item(OP_LOAD, 6'd0);
        send_item(OP_LOAD, 6'd0);
        send_item(OP_LOAD, 6'd63);
        send_item(OP_LOAD, 6'd5);
        send_item(OP_LOAD, 6'd63);
        send_item(OP_LOAD, 6'd42);
        send_item(OP_QUERY, 6'd0);
        send_item(OP_QUERY, 6'd42);
        send_item(OP_QUERY, 6'd63);
        send_item(OP_QUERY, 6'd42);
        send_item(OP_QUERY, 6'd42);
        send_item(OP_QUERY, SPARE_A);
        send_item(OP_QUERY, 6'd5);
        send_item(OP_LOAD, 6'd21);
        send_item(OP_QUERY, 6'd21);
        send_item(OP_QUERY, 6'd0);
        send_item(OP_QUERY, 6'd63);
        wait_for_ranks();
    endtask

    task automatic test_random_sequences();
        int load_pct;
        for (int phase = 0; phase < 6; phase++) begin
            load_pct = $urandom_range(5, 90);
            for (int i = 0; i < 100; i++) begin
                if ($urandom_range(0, 99) < load_pct)
                    send_item(OP_LOAD, pick_load_color());
                else if ($urandom_range(0, 99) < 85)
                    send_item(OP_QUERY, pick_present());
                else
                    send_item(OP_QUERY, COLOR_W'($urandom_range(0, NUM_COLORS - 1)));
            end
            if ($urandom_range(0, 1) == 0)
                wait_for_ranks();
        end
        wait_for_ranks();
    endtask

    // receiver holds off long enough for the core to fill and stall its input
    task automatic test_result_backpressure();
        wait_for_ranks();
        burst_left = 1000;
        hold_requests++;
        for (int i = 0; i < 5; i++)
            send_item(OP_QUERY, pick_present());
        send_item(OP_LOAD, pick_load_color());
        send_item(OP_QUERY, pick_present());
        burst_left = 0;
        wait_for_ranks();
    endtask

    task automatic test_full_deck();
        while (cards_seen < MAX_DECK - 1)
            send_item(OP_LOAD, pick_load_color());
        send_item(OP_LOAD, SPARE_A);
        send_item(OP_LOAD, SPARE_B);
        send_item(OP_LOAD, 6'd0);
        send_item(OP_QUERY, SPARE_A);
        send_item(OP_QUERY, SPARE_B);
        send_item(OP_QUERY, SPARE_A);
        for (int i = 0; i < 40; i++) begin
            if ($urandom_range(0, 3) == 0)
                send_item(OP_LOAD, COLOR_W'($urandom_range(0, NUM_COLORS - 1)));
            else
                send_item(OP_QUERY, pick_present());
        end
        send_item(OP_QUERY, SPARE_B);
        wait_for_ranks();
    endtask

    // result check against the oldest pending answer
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (ranks_due.size() == 0) begin
                report_mismatch("result with nothing pending, position", 0,
                                int'(m_tdata[POS_W-1:0]));
            end else begin
                want_rank = ranks_due.pop_front();
                if (m_tdata[POS_W-1:0] !== want_rank.position)
                    report_mismatch("position", int'(want_rank.position),
                                    int'(m_tdata[POS_W-1:0]));
                if (m_tuser[0] !== want_rank.not_found)
                    report_mismatch("not_found", int'(want_rank.not_found), int'(m_tuser[0]));
            end
        end
    end

    // receiver stall pattern, with an occasional long hold-off
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else if (rx_left > 0) begin
            rx_left <= rx_left - 1;
            case (rx_mode)
                RX_FREE: m_tready <= 1'b1;
                RX_CHOP: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= 1'b0;
            endcase
        end else begin
            rx_mode  <= $urandom_range(RX_FREE, RX_STALL);
            rx_left  <= $urandom_range(1, 120);
            m_tready <= 1'b1;
        end
    end

    initial begin
        while (cycle_cnt < WATCHDOG_CYCLES) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        for (int k = 0; k < NUM_COLORS; k++)
            deck_rank[k] = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_moves();
        test_random_sequences();
        test_result_backpressure();
        test_full_deck();
        wait_for_ranks();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
